@@ src/dwt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwt_pkg
// Shared codes, field widths and inter-cell types for the data watchpoint
// table.
// ----------------------------------------------------------------------------
package dwt_pkg;

   localparam int ENTRIES_DEF   = 8;
   localparam int PAGE_BITS_DEF = 12;

   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 64;
   localparam int RANGE_W  = 13;
   localparam int KIND_W   = 2;
   localparam int ABYTES_W = 5;
   localparam int SELNUM_W = 4;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 3;

   localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLR   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CROSS   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADSLOT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNSET   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd5;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                match_en;
      logic                update_en;
      logic [CMD_W-1:0]    op;
      logic                set_ok;
      logic                access_live;
      logic [KIND_W-1:0]   kind;
      logic [SELNUM_W-1:0] sel;
   } dwt_ctl_type;

   // word handed from one cell to the next
   typedef struct packed {
      logic                free_found;
      logic [SELNUM_W-1:0] free_idx;
      logic                hit_found;
      logic [SELNUM_W-1:0] hit_idx;
      logic                sel_valid;
      logic                any;
   } dwt_link_type;

endpackage

@@ src/data_watchpoint_table_core.sv @@
`timescale 1ns / 1ps
// The result strobe is registered from the commit step. Busy is high through the
// prepare, match and commit steps that follow acceptance, which are set by operand
// preparation (64-bit adder), the per-cell range compare and the priority chain
// through the cells; no new command is taken until they end. The receiver cannot stall.
// Reset clears every valid bit, the sequencer and the result strobe.
// ----------------------------------------------------------------------------
// data_watchpoint_table_core
// Watchpoint table built as a row of slot cells with a three-step sequencer:
// set, delete one, delete all and access check.
// ----------------------------------------------------------------------------
module data_watchpoint_table_core #(
   parameter int ENTRIES   = dwt_pkg::ENTRIES_DEF,
   parameter int PAGE_BITS = dwt_pkg::PAGE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dwt_pkg::CMD_W-1:0]       req_cmd,
   input  logic [dwt_pkg::ADDR_W-1:0]      req_address,
   input  logic [dwt_pkg::RANGE_W-1:0]     req_range_bytes,
   input  logic [dwt_pkg::KIND_W-1:0]      req_access_kind,
   input  logic [dwt_pkg::ABYTES_W-1:0]    req_access_bytes,
   input  logic [dwt_pkg::SELNUM_W-1:0]    req_slot_number,
   output logic                            rsp_valid,
   output logic [dwt_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_hit,
   output logic [dwt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                            rsp_any_set
);
   import dwt_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_PREP   = 2'd1;
   localparam logic [1:0] PH_MATCH  = 2'd2;
   localparam logic [1:0] PH_COMMIT = 2'd3;

   localparam logic [SELNUM_W:0] ENTRIES_V = (SELNUM_W+1)'(ENTRIES);

   logic [1:0]            phase_ff, phase_in;
   logic                  accept;

   logic [CMD_W-1:0]      cmd_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [RANGE_W-1:0]    range_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic [ABYTES_W-1:0]   abytes_ff;
   logic [SELNUM_W-1:0]   sel_ff;

   logic [ADDR_W:0]       sum;
   logic [ADDR_W-1:0]     last_in, last_ff;
   logic                  cross_in, cross_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_any_ff;

   dwt_ctl_type           ctl;
   dwt_link_type          link [ENTRIES+1];

   assign busy   = (phase_ff != PH_IDLE);
   assign accept = start && !busy;

   always_comb begin
      case (phase_ff)
         PH_IDLE:   phase_in = accept ? PH_PREP : PH_IDLE;
         PH_PREP:   phase_in = PH_MATCH;
         PH_MATCH:  phase_in = PH_COMMIT;
         default:   phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         addr_ff   <= req_address;
         range_ff  <= req_range_bytes;
         kind_ff   <= req_access_kind;
         abytes_ff <= req_access_bytes;
         sel_ff    <= req_slot_number;
      end
   end

   // last byte of the set range or of the access; an access that runs past
   // the top of the address space is clipped to the top
   assign sum = {1'b0, addr_ff}
              + ((cmd_ff == CMD_SET) ? (ADDR_W+1)'(range_ff) : (ADDR_W+1)'(abytes_ff))
              - (ADDR_W+1)'(1);
   assign last_in  = ((cmd_ff == CMD_CHECK) && sum[ADDR_W]) ? '1 : sum[ADDR_W-1:0];
   assign cross_in = sum[ADDR_W] || (addr_ff[ADDR_W-1:PAGE_BITS] != sum[ADDR_W-1:PAGE_BITS]);

   always_ff @(posedge clock) begin
      if (phase_ff == PH_PREP) begin
         last_ff  <= last_in;
         cross_ff <= cross_in;
      end
   end

   always_comb begin
      ctl.match_en    = (phase_ff == PH_MATCH);
      ctl.update_en   = (phase_ff == PH_COMMIT);
      ctl.op          = cmd_ff;
      ctl.set_ok      = (range_ff != '0) && !cross_ff;
      ctl.access_live = (abytes_ff != '0);
      ctl.kind        = kind_ff;
      ctl.sel         = sel_ff;
   end

   assign link[0] = '0;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      dwt_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .addr     (addr_ff),
         .last     (last_ff),
         .link_in  (link[k]),
         .link_out (link[k+1])
      );
   end

   always_comb begin
      rsp_status_in = ST_OK;
      rsp_hit_in    = 1'b0;
      rsp_slot_in   = '0;
      case (cmd_ff)
         CMD_SET: begin
            if (!link[ENTRIES].free_found) begin
               rsp_status_in = ST_FULL;
            end else if (range_ff == '0) begin
               rsp_status_in = ST_ZERO;
            end else if (cross_ff) begin
               rsp_status_in = ST_CROSS;
            end else begin
               rsp_slot_in = link[ENTRIES].free_idx[SLOT_W-1:0];
            end
         end
         CMD_DEL: begin
            if ({1'b0, sel_ff} >= ENTRIES_V) begin
               rsp_status_in = ST_BADSLOT;
            end else if (!link[ENTRIES].sel_valid) begin
               rsp_status_in = ST_UNSET;
            end
         end
         CMD_CHECK: begin
            rsp_hit_in = link[ENTRIES].hit_found;
            if (link[ENTRIES].hit_found) begin
               rsp_slot_in = link[ENTRIES].hit_idx[SLOT_W-1:0];
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   assign rsp_valid_in = (phase_ff == PH_COMMIT);

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_any_ff    <= link[ENTRIES].any;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_any_set = rsp_any_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("result word not on time");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("sequencer still busy while result shown");

   a_hit_only_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (cmd_ff == CMD_CHECK) && (rsp_status == ST_OK))
      else $error("hit on a non-check word");

   a_set_marks_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cmd_ff == CMD_SET) && (rsp_status == ST_OK) |-> rsp_any_set)
      else $error("successful set left table empty");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cmd_ff == CMD_CLR) |-> !rsp_any_set && (rsp_status == ST_OK))
      else $error("delete-all left a slot in use");
`endif

endmodule

@@ src/dwt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwt_cell
// One watchpoint slot: holds start, end and mask, compares an access against
// its range and passes the lowest-free and lowest-hit search to its neighbour.
// ----------------------------------------------------------------------------
module dwt_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dwt_pkg::dwt_ctl_type                ctl,
   input  logic [dwt_pkg::ADDR_W-1:0]          addr,
   input  logic [dwt_pkg::ADDR_W-1:0]          last,
   input  dwt_pkg::dwt_link_type               link_in,
   output dwt_pkg::dwt_link_type               link_out
);
   import dwt_pkg::*;

   localparam logic [SELNUM_W-1:0] MY_IDX = SELNUM_W'(CELL_INDEX);

   logic                valid_ff, valid_in;
   logic [ADDR_W-1:0]   start_ff;
   logic [ADDR_W-1:0]   end_ff;
   logic [KIND_W-1:0]   access_ff;
   logic                match_ff, match_in;
   logic                sel_hit, claim, take;

   // end is stored inclusive; a stored range never wraps
   assign match_in = valid_ff && ((access_ff & ctl.kind) != '0) && ctl.access_live
                     && !(end_ff < addr) && !(start_ff > last);

   assign sel_hit = (ctl.sel == MY_IDX);
   assign claim   = !valid_ff && !link_in.free_found;
   assign take    = (ctl.op == CMD_SET) && ctl.set_ok && claim;

   always_comb begin
      case (ctl.op)
         CMD_CLR:   valid_in = 1'b0;
         CMD_SET:   valid_in = valid_ff | take;
         CMD_DEL:   valid_in = valid_ff & !sel_hit;
         default:   valid_in = valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.update_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update_en && take) begin
         start_ff  <= addr;
         end_ff    <= last;
         access_ff <= ctl.kind;
      end
      if (ctl.match_en) begin
         match_ff <= match_in;
      end
   end

   always_comb begin
      link_out.free_found = link_in.free_found | !valid_ff;
      link_out.free_idx   = link_in.free_found ? link_in.free_idx : MY_IDX;
      link_out.hit_found  = link_in.hit_found | match_ff;
      link_out.hit_idx    = link_in.hit_found ? link_in.hit_idx : MY_IDX;
      link_out.sel_valid  = link_in.sel_valid | (valid_ff & sel_hit);
      link_out.any        = link_in.any | valid_in;
   end

endmodule
